// ===== src/cbpg_pkg.sv =====
// Shared types and constants for the cubic Bezier point generator.
package cbpg_pkg;

  localparam int SEG_W      = 7;
  localparam int CFG_DATA_W = 63;
  localparam int CFG_IDX_W  = 3;
  localparam int NUM_CP     = 4;
  localparam int CP_IDX_W   = 2;
  localparam int NUM_AXES   = 3;
  localparam int WGT_OPS    = 6;
  localparam int MAC_OPS    = 8;

  localparam int AXIS_X = 0;
  localparam int AXIS_Y = 1;
  localparam int AXIS_Z = 2;

  localparam logic [CFG_IDX_W-1:0] REG_CP0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CP1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CP2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CP3 = 3'd3;

  typedef enum logic [2:0] {
    WOP_UU = 3'd0,
    WOP_TT = 3'd1,
    WOP_W0 = 3'd2,
    WOP_W1 = 3'd3,
    WOP_W2 = 3'd4,
    WOP_W3 = 3'd5
  } wgt_op_t;

  typedef struct packed {
    logic                start;
    logic                div_step;
    logic                advance;
    logic                wgt_en;
    wgt_op_t             wgt_op;
    logic                mac_en;
    logic [CP_IDX_W-1:0] mac_k;
    logic                mac_hi;
    logic                load_out;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic seg_zero;
  } status_t;

endpackage

// ===== src/cubic_bezier_point_generator_core.sv =====
// Top level of the cubic Bezier point generator: controller plus datapath.
//
//   channel   signals                                      direction
//   cfg       cfg_write, cfg_index, cfg_data               in, write only
//   seg       seg_valid, seg_stall, segments               in
//   point     point_valid, point_stall, point_x/y/z,       out
//             point_index, last_point
//
// An item with n segments is accepted and runs the serial divider for
// 2^T_FRAC_BITS / n; each point then takes a step, 6 weight
// products on one shared multiplier, 8 half-weight MACs plus one drain and
// an output load.
// One item at a time; seg_stall is high after a nonzero item is taken till its last point loads.
// A stalled output holds the datapath in its emit step. Reset is synchronous, active high.
module cubic_bezier_point_generator_core #(
  parameter int MAX_SEGMENTS = 64,
  parameter int COORD_WIDTH  = 21,
  parameter int T_FRAC_BITS  = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [cbpg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cbpg_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              seg_valid,
  output logic                              seg_stall,
  input  logic [cbpg_pkg::SEG_W-1:0]        segments,
  output logic                              point_valid,
  input  logic                              point_stall,
  output logic signed [COORD_WIDTH-1:0]     point_x,
  output logic signed [COORD_WIDTH-1:0]     point_y,
  output logic signed [COORD_WIDTH-1:0]     point_z,
  output logic [cbpg_pkg::SEG_W-1:0]        point_index,
  output logic                              last_point
);

  cbpg_pkg::cmd_t    cmd;
  cbpg_pkg::status_t status;

  cbpg_ctrl #(
    .T_FRAC_BITS (T_FRAC_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .seg_valid   (seg_valid),
    .seg_stall   (seg_stall),
    .point_valid (point_valid),
    .point_stall (point_stall),
    .status      (status),
    .cmd         (cmd)
  );

  cbpg_datapath #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .COORD_WIDTH  (COORD_WIDTH),
    .T_FRAC_BITS  (T_FRAC_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .segments    (segments),
    .cmd         (cmd),
    .status      (status),
    .point_x     (point_x),
    .point_y     (point_y),
    .point_z     (point_z),
    .point_index (point_index),
    .last_point  (last_point)
  );

`ifndef SYNTHESIS
  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    (seg_valid && !seg_stall && (segments != '0)) |=> seg_stall)
    else $error("run with points did not hold off the next item");

  a_index_nonzero: assert property (@(posedge clk) disable iff (rst)
    point_valid |-> (point_index != '0))
    else $error("point shown with index zero");

  a_index_in_range: assert property (@(posedge clk) disable iff (rst)
    point_valid |-> (point_index <= cbpg_pkg::SEG_W'(MAX_SEGMENTS)))
    else $error("point index above the segment limit");

  a_gap_after_last: assert property (@(posedge clk) disable iff (rst)
    (point_valid && !point_stall && last_point) |=> !point_valid)
    else $error("point shown right after the last point of a run");
`endif

endmodule

// ===== src/cbpg_ctrl.sv =====
// Sequencer for the Bezier point generator: divide, step, weight, accumulate and emit phases.
module cbpg_ctrl #(
  parameter int T_FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               seg_valid,
  output logic               seg_stall,
  output logic               point_valid,
  input  logic               point_stall,
  input  cbpg_pkg::status_t  status,
  output cbpg_pkg::cmd_t     cmd
);

  localparam int CNT_W = $clog2(T_FRAC_BITS + 2);
  localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(T_FRAC_BITS);
  localparam logic [CNT_W-1:0] WGT_LAST  = CNT_W'(cbpg_pkg::WGT_OPS - 1);
  localparam logic [CNT_W-1:0] MAC_DRAIN = CNT_W'(cbpg_pkg::MAC_OPS);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_DIV  = 6'b000010,
    S_STEP = 6'b000100,
    S_WGT  = 6'b001000,
    S_MAC  = 6'b010000,
    S_EMIT = 6'b100000
  } state_t;

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             point_valid_next;
  logic             out_free;

  assign out_free  = !point_valid || !point_stall;
  assign seg_stall = (state != S_IDLE);

  always_comb begin
    cmd              = '0;
    state_next       = state;
    cnt_next         = cnt;
    point_valid_next = point_valid && point_stall;
    case (state)
      S_IDLE: begin
        if (seg_valid) begin
          cmd.start = 1'b1;
          cnt_next  = '0;
          if (!status.seg_zero) begin
            state_next = S_DIV;
          end
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + CNT_W'(1);
        if (cnt == DIV_LAST) begin
          state_next = S_STEP;
        end
      end
      S_STEP: begin
        cmd.advance = 1'b1;
        cnt_next    = '0;
        state_next  = S_WGT;
      end
      S_WGT: begin
        cmd.wgt_en = 1'b1;
        case (cnt)
          CNT_W'(0): cmd.wgt_op = cbpg_pkg::WOP_UU;
          CNT_W'(1): cmd.wgt_op = cbpg_pkg::WOP_TT;
          CNT_W'(2): cmd.wgt_op = cbpg_pkg::WOP_W0;
          CNT_W'(3): cmd.wgt_op = cbpg_pkg::WOP_W1;
          CNT_W'(4): cmd.wgt_op = cbpg_pkg::WOP_W2;
          default:   cmd.wgt_op = cbpg_pkg::WOP_W3;
        endcase
        cnt_next = cnt + CNT_W'(1);
        if (cnt == WGT_LAST) begin
          cnt_next   = '0;
          state_next = S_MAC;
        end
      end
      S_MAC: begin
        if (cnt != MAC_DRAIN) begin
          cmd.mac_en = 1'b1;
          cmd.mac_k  = cnt[2:1];
          cmd.mac_hi = cnt[0];
          cnt_next   = cnt + CNT_W'(1);
        end else begin
          // last product is being summed this cycle
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          cmd.load_out     = 1'b1;
          point_valid_next = 1'b1;
          state_next       = status.last ? S_IDLE : S_STEP;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      cnt         <= '0;
      point_valid <= 1'b0;
    end else begin
      state       <= state_next;
      cnt         <= cnt_next;
      point_valid <= point_valid_next;
    end
  end

endmodule

// ===== src/cbpg_datapath.sv =====
// Datapath: control point store, t stepper, weight unit, per-axis accumulators, output register.
module cbpg_datapath #(
  parameter int MAX_SEGMENTS = 64,
  parameter int COORD_WIDTH  = 21,
  parameter int T_FRAC_BITS  = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [cbpg_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [cbpg_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic [cbpg_pkg::SEG_W-1:0]           segments,
  input  cbpg_pkg::cmd_t                       cmd,
  output cbpg_pkg::status_t                    status,
  output logic signed [COORD_WIDTH-1:0]        point_x,
  output logic signed [COORD_WIDTH-1:0]        point_y,
  output logic signed [COORD_WIDTH-1:0]        point_z,
  output logic [cbpg_pkg::SEG_W-1:0]           point_index,
  output logic                                 last_point
);

  localparam int SW    = cbpg_pkg::SEG_W;
  localparam int TW    = T_FRAC_BITS + 1;
  localparam int SQW   = 2 * T_FRAC_BITS + 1;
  localparam int WW    = 3 * T_FRAC_BITS + 1;
  localparam int WPW   = SQW + TW;
  localparam int HLO   = (WW + 1) / 2;
  localparam int CF    = COORD_WIDTH + 2;
  localparam int MW    = CF + HLO + 1;
  localparam int AW    = COORD_WIDTH + 3 * T_FRAC_BITS + 3;
  localparam int SHIFT = 3 * T_FRAC_BITS;

  localparam logic [TW-1:0] T_ONE   = {1'b1, {T_FRAC_BITS{1'b0}}};
  localparam logic [SW-1:0] SEG_MAX = SW'(MAX_SEGMENTS);

  // coefficients, handle points stored premultiplied by 3
  logic signed [CF-1:0] coef [cbpg_pkg::NUM_CP][cbpg_pkg::NUM_AXES];
  logic signed [CF-1:0] cfg_coef [cbpg_pkg::NUM_AXES];
  logic                 cfg_is_handle;

  always_comb begin
    logic signed [COORD_WIDTH-1:0] fld;
    logic signed [CF-1:0]          ext;
    cfg_is_handle = (cfg_index == cbpg_pkg::REG_CP1) || (cfg_index == cbpg_pkg::REG_CP2);
    for (int a = 0; a < cbpg_pkg::NUM_AXES; a++) begin
      fld         = cfg_data[a*COORD_WIDTH +: COORD_WIDTH];
      ext         = CF'(fld);
      cfg_coef[a] = cfg_is_handle ? (ext <<< 1) + ext : ext;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < cbpg_pkg::NUM_CP; k++) begin
        for (int a = 0; a < cbpg_pkg::NUM_AXES; a++) begin
          coef[k][a] <= '0;
        end
      end
    end else if (cfg_write && (cfg_index <= cbpg_pkg::REG_CP3)) begin
      for (int a = 0; a < cbpg_pkg::NUM_AXES; a++) begin
        coef[cfg_index[cbpg_pkg::CP_IDX_W-1:0]][a] <= cfg_coef[a];
      end
    end
  end

  // run control: segment count, index, t = floor(i * 2^F / n) stepped by remainder
  logic [SW-1:0] seg_n, step_i, step_r, div_rem;
  logic [TW-1:0] div_q, t_val, u_val;
  logic [SW-1:0] seg_sat;
  logic [SW:0]   rem_sh, r_sum;
  logic          div_ge, r_wrap;
  logic [SW-1:0] rem_new, r_new;
  logic [TW-1:0] t_new;

  assign seg_sat = (segments > SEG_MAX) ? SEG_MAX : segments;
  assign rem_sh  = {div_rem, div_q[TW-1]};
  assign div_ge  = rem_sh >= {1'b0, seg_n};
  assign rem_new = div_ge ? SW'(rem_sh - {1'b0, seg_n}) : SW'(rem_sh);
  assign r_sum   = {1'b0, step_r} + {1'b0, div_rem};
  assign r_wrap  = r_sum >= {1'b0, seg_n};
  assign r_new   = r_wrap ? SW'(r_sum - {1'b0, seg_n}) : SW'(r_sum);
  assign t_new   = t_val + div_q + TW'(r_wrap);

  assign status.seg_zero = (segments == '0);
  assign status.last     = (step_i == seg_n);

  always_ff @(posedge clk) begin
    if (rst) begin
      seg_n  <= '0;
      step_i <= '0;
    end else if (cmd.start) begin
      seg_n  <= seg_sat;
      step_i <= '0;
    end else if (cmd.advance) begin
      step_i <= step_i + SW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      div_rem <= '0;
      div_q   <= T_ONE;
      step_r  <= '0;
      t_val   <= '0;
    end
    if (cmd.div_step) begin
      div_rem <= rem_new;
      div_q   <= {div_q[TW-2:0], div_ge};
    end
    if (cmd.advance) begin
      step_r <= r_new;
      t_val  <= t_new;
      u_val  <= T_ONE - t_new;
    end
  end

  // Bernstein weights without the factor 3, one product a cycle
  logic [SQW-1:0] sq_uu, sq_tt;
  logic [WW-1:0]  wgt [cbpg_pkg::NUM_CP];
  logic [SQW-1:0] wa;
  logic [TW-1:0]  wb;
  logic [WPW-1:0] wprod;

  always_comb begin
    case (cmd.wgt_op)
      cbpg_pkg::WOP_UU: begin wa = SQW'(u_val); wb = u_val; end
      cbpg_pkg::WOP_TT: begin wa = SQW'(t_val); wb = t_val; end
      cbpg_pkg::WOP_W0: begin wa = sq_uu;       wb = u_val; end
      cbpg_pkg::WOP_W1: begin wa = sq_uu;       wb = t_val; end
      cbpg_pkg::WOP_W2: begin wa = sq_tt;       wb = u_val; end
      default:          begin wa = sq_tt;       wb = t_val; end
    endcase
  end

  assign wprod = wa * wb;

  always_ff @(posedge clk) begin
    if (cmd.wgt_en) begin
      case (cmd.wgt_op)
        cbpg_pkg::WOP_UU: sq_uu  <= wprod[SQW-1:0];
        cbpg_pkg::WOP_TT: sq_tt  <= wprod[SQW-1:0];
        cbpg_pkg::WOP_W0: wgt[0] <= wprod[WW-1:0];
        cbpg_pkg::WOP_W1: wgt[1] <= wprod[WW-1:0];
        cbpg_pkg::WOP_W2: wgt[2] <= wprod[WW-1:0];
        default:          wgt[3] <= wprod[WW-1:0];
      endcase
    end
  end

  // per-axis multiply-accumulate, weight taken in two halves
  logic [WW-1:0]        wsel;
  logic [HLO-1:0]       whalf;
  logic signed [HLO:0]  whalf_s;
  logic signed [MW-1:0] prod [cbpg_pkg::NUM_AXES];
  logic signed [MW-1:0] prod_next [cbpg_pkg::NUM_AXES];
  logic signed [AW-1:0] acc [cbpg_pkg::NUM_AXES];
  logic signed [AW-1:0] addend [cbpg_pkg::NUM_AXES];
  logic                 prod_pend, prod_hi;

  assign wsel    = wgt[cmd.mac_k];
  assign whalf   = cmd.mac_hi ? HLO'(wsel[WW-1:HLO]) : wsel[HLO-1:0];
  assign whalf_s = {1'b0, whalf};

  always_comb begin
    for (int a = 0; a < cbpg_pkg::NUM_AXES; a++) begin
      prod_next[a] = coef[cmd.mac_k][a] * whalf_s;
      addend[a]    = prod_hi ? (AW'(prod[a]) <<< HLO) : AW'(prod[a]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_pend <= 1'b0;
    end else begin
      prod_pend <= cmd.mac_en;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mac_en) begin
      prod_hi <= cmd.mac_hi;
      for (int a = 0; a < cbpg_pkg::NUM_AXES; a++) begin
        prod[a] <= prod_next[a];
      end
    end
    for (int a = 0; a < cbpg_pkg::NUM_AXES; a++) begin
      if (cmd.advance) begin
        acc[a] <= '0;
      end else if (prod_pend) begin
        acc[a] <= acc[a] + addend[a];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      point_x     <= acc[cbpg_pkg::AXIS_X][SHIFT +: COORD_WIDTH];
      point_y     <= acc[cbpg_pkg::AXIS_Y][SHIFT +: COORD_WIDTH];
      point_z     <= acc[cbpg_pkg::AXIS_Z][SHIFT +: COORD_WIDTH];
      point_index <= step_i;
      last_point  <= status.last;
    end
  end

endmodule
